// File: rtl/interval_partition_dp_macros.svh
// ----------------------------------------------------------------------------
// interval_partition_dp_macros.svh
// Assertion macros for the interval partition block.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_PARTITION_DP_MACROS_SVH
`define INTERVAL_PARTITION_DP_MACROS_SVH
`ifndef SYNTHESIS
`define IPDP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipdp: implication check failed");
`define IPDP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipdp: next-cycle check failed");
`else
`define IPDP_ASSERT_IMP(label, clk, rst, ante, cons)
`define IPDP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ipdp_pkg.sv
// ----------------------------------------------------------------------------
// ipdp_pkg
// Shared constants and codes for the interval partition block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ipdp_pkg;
  localparam int MAX_POSITIONS_DEF = 32;
  localparam int COST_BITS_DEF     = 32;
  localparam int PATH_BITS         = 40;
  localparam int SIZE_W            = 6;
  localparam int BND_W             = 6;
  localparam int SEG_COST_W        = 32;
  localparam int CFG_IDX_W         = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBLEM_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LIMIT = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;
endpackage

// File: rtl/ipdp_if.sv
// ----------------------------------------------------------------------------
// ipdp_if
// Valid/ready channels for cost/solve items and boundary results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ipdp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [5:0]         seg_start;
  logic [5:0]         seg_end;
  logic signed [31:0] seg_cost;
  modport source (output valid, command, seg_start, seg_end, seg_cost, input ready);
  modport sink   (input valid, command, seg_start, seg_end, seg_cost, output ready);
endinterface

interface ipdp_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] boundary;
  logic       is_last;
  modport source (output valid, boundary, is_last, input ready);
  modport sink   (input valid, boundary, is_last, output ready);
endinterface

// File: rtl/ipdp_ram.sv
// ----------------------------------------------------------------------------
// ipdp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ipdp_ram #(
  parameter int W  = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [(1<<AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/interval_partition_dp.sv
// Cost writes stream at one transaction per cycle while the block is idle; a solve holds
// the input off. A solve runs rounds k=1..kmax over positions i=1..n, scanning each
// position's candidate splits with one read per cycle of the cost and path-row memories;
// the traceback then walks the back pointers from round kopt down, and the boundaries
// are emitted in order, each waiting for the receiver.
// Reset (rst, sync, high): sizes go to 32, controller idles; memories keep contents.
// ----------------------------------------------------------------------------
// interval_partition_dp
// Minimum-cost interval partition: cost table load, DP solve, traceback, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interval_partition_dp_macros.svh"
module interval_partition_dp import ipdp_pkg::*; #(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int COST_BITS     = COST_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  ipdp_in_if.sink              in_ch,
  ipdp_out_if.source           out_ch
);
  // index widths
  localparam int IW    = $clog2(MAX_POSITIONS);      // 0-based position
  localparam int PW    = $clog2(MAX_POSITIONS + 1);  // 1-based position / round
  localparam int SUM_W = ((COST_BITS > PATH_BITS) ? COST_BITS : PATH_BITS) + 1;
  localparam int CIN_W = (COST_BITS > SEG_COST_W) ? COST_BITS : SEG_COST_W;
  localparam int PD_W  = PATH_BITS + SIZE_W;         // path row entry: {count, cost}

  localparam logic signed [SUM_W-1:0] PATH_HI = SUM_W'((64'sd1 <<< (PATH_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] PATH_LO = -PATH_HI - SUM_W'(1);
  localparam logic signed [CIN_W-1:0] COST_HI = CIN_W'((64'sd1 <<< (COST_BITS - 1)) - 64'sd1);
  localparam logic signed [CIN_W-1:0] COST_LO = -COST_HI - CIN_W'(1);
  localparam logic [SIZE_W-1:0]       MAXP    = SIZE_W'(MAX_POSITIONS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SFIN, S_TSUM, S_TCNT, S_TRD, S_TWR, S_ERD, S_EWAIT
  } state_t;

  state_t state;

  // configuration
  logic [SIZE_W-1:0] problem_size, segment_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      problem_size  <= SIZE_W'(32);
      segment_limit <= SIZE_W'(32);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PROBLEM_SIZE:  problem_size  <= cfg_data;
        CFG_SEGMENT_LIMIT: segment_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side
  logic in_acc;
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // effective sizes, taken at solve time
  logic [SIZE_W-1:0] n_eff, kmax_eff;
  assign n_eff    = (problem_size > MAXP) ? MAXP : problem_size;
  assign kmax_eff = (segment_limit > n_eff) ? n_eff : segment_limit;

  // cost write: sign-extend then clamp to COST_BITS
  logic signed [CIN_W-1:0]     cin, cin_sat;
  logic                        cost_we;
  logic [2*IW-1:0]             cost_waddr, cost_raddr;
  logic [COST_BITS-1:0]        cost_raw;
  logic signed [COST_BITS-1:0] cost_rd;

  assign cin     = CIN_W'(in_ch.seg_cost);
  assign cin_sat = (cin > COST_HI) ? COST_HI : ((cin < COST_LO) ? COST_LO : cin);
  assign cost_we = in_acc && (in_ch.command == CMD_WRITE)
                   && (in_ch.seg_start != '0) && (in_ch.seg_start <= MAXP)
                   && (in_ch.seg_end != '0) && (in_ch.seg_end <= MAXP);
  assign cost_waddr = {IW'(in_ch.seg_start - 6'd1), IW'(in_ch.seg_end - 6'd1)};

  // DP control registers
  logic [PW-1:0] n_r, kmax_r, k_r, i_r, c_r, kopt_r, j_r, p_c;
  logic          p_v;
  logic signed [PATH_BITS-1:0] best;
  logic [SIZE_W-1:0]           best_cnt;
  logic [PW-1:0]               best_pick;

  // row k[0] is written in round k, row ~k[0] holds round k-1
  assign cost_raddr = {IW'(c_r), IW'(i_r - PW'(1))};

  ipdp_ram #(.W(COST_BITS), .AW(2*IW)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(COST_BITS'(cin_sat)),
    .re(state == S_SCAN), .raddr(cost_raddr), .rdata(cost_raw)
  );
  assign cost_rd = $signed(cost_raw);

  logic            path_we, path_re;
  logic [PW:0]     path_waddr, path_raddr;
  logic [PD_W-1:0] path_wdata, path_rdata;
  logic signed [PATH_BITS-1:0] path_rd;
  logic [SIZE_W-1:0]           cnt_rd;

  assign path_re    = (state == S_SCAN) || (state == S_TSUM);
  assign path_raddr = (state == S_TSUM) ? {kmax_r[0], n_r} : {~k_r[0], c_r};
  assign path_rd    = $signed(path_rdata[PATH_BITS-1:0]);
  assign cnt_rd     = path_rdata[PD_W-1:PATH_BITS];

  ipdp_ram #(.W(PD_W), .AW(PW+1)) u_path (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .re(path_re), .raddr(path_raddr), .rdata(path_rdata)
  );

  // candidate from the read that came back this cycle
  logic signed [SUM_W-1:0]     sum_w;
  logic signed [PATH_BITS-1:0] cand, nb;
  logic [SIZE_W-1:0]           cand_cnt, nb_cnt;
  logic [PW-1:0]               nb_pick;
  logic                        take;

  always_comb begin
    if (p_c == '0) begin
      sum_w    = SUM_W'(cost_rd);
      cand_cnt = SIZE_W'(1);
    end else begin
      sum_w    = SUM_W'(path_rd) + SUM_W'(cost_rd);
      cand_cnt = cnt_rd + SIZE_W'(1);
    end
    cand = PATH_BITS'((sum_w > PATH_HI) ? PATH_HI : ((sum_w < PATH_LO) ? PATH_LO : sum_w));
    take = (p_c == '0) || (cand < best) || ((cand == best) && (cand_cnt < best_cnt));
    nb      = take ? cand : best;
    nb_cnt  = take ? cand_cnt : best_cnt;
    nb_pick = take ? ((p_c == '0) ? i_r : p_c) : best_pick;
  end

  assign path_we    = (state == S_SFIN);
  assign path_waddr = {k_r[0], i_r};
  assign path_wdata = {nb_cnt, nb};

  // back pointers, addressed {position, round}
  logic [PW-1:0] bp_rd;
  ipdp_ram #(.W(PW), .AW(2*PW)) u_bp (
    .clk(clk), .we(state == S_SFIN), .waddr({i_r, k_r}), .wdata(nb_pick),
    .re(state == S_TRD), .raddr({i_r, k_r}), .rdata(bp_rd)
  );

  // traced boundaries; entries 0 and kopt are synthesized at emit time
  logic [BND_W-1:0] buf_rd;
  ipdp_ram #(.W(BND_W), .AW(PW)) u_buf (
    .clk(clk), .we(state == S_TWR), .waddr(k_r - PW'(1)),
    .wdata(BND_W'(bp_rd) + BND_W'(1)),
    .re((state == S_ERD) && (j_r != '0) && (j_r != kopt_r)), .raddr(j_r),
    .rdata(buf_rd)
  );

  logic [SIZE_W-1:0] kopt_c;
  assign kopt_c = (cnt_rd == '0) ? SIZE_W'(1) :
                  ((cnt_rd > SIZE_W'(kmax_r)) ? SIZE_W'(kmax_r) : cnt_rd);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      p_v          <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // S_EWAIT reloads the output register itself whenever ready is high
      if (out_ch.ready && (state != S_EWAIT)) begin
        out_ch.valid <= 1'b0;
      end
      if (p_v) begin
        best      <= nb;
        best_cnt  <= nb_cnt;
        best_pick <= nb_pick;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.command == CMD_SOLVE)) begin
            n_r    <= PW'(n_eff);
            kmax_r <= PW'(kmax_eff);
            j_r    <= '0;
            if ((kmax_eff <= SIZE_W'(1)) || (n_eff <= SIZE_W'(1))) begin
              kopt_r <= PW'(1);
              state  <= S_ERD;
            end else begin
              k_r   <= PW'(1);
              i_r   <= PW'(1);
              c_r   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          p_v <= 1'b1;
          p_c <= c_r;
          if ((k_r == PW'(1)) || (c_r == i_r - PW'(1))) begin
            state <= S_SFIN;
          end else begin
            c_r <= c_r + PW'(1);
          end
        end
        S_SFIN: begin
          p_v <= 1'b0;
          c_r <= '0;
          if (i_r == n_r) begin
            if (k_r == kmax_r) begin
              state <= S_TSUM;
            end else begin
              k_r   <= k_r + PW'(1);
              i_r   <= PW'(1);
              state <= S_SCAN;
            end
          end else begin
            i_r   <= i_r + PW'(1);
            state <= S_SCAN;
          end
        end
        S_TSUM: state <= S_TCNT;
        S_TCNT: begin
          kopt_r <= PW'(kopt_c);
          k_r    <= PW'(kopt_c);
          i_r    <= n_r;
          state  <= (kopt_c == SIZE_W'(1)) ? S_ERD : S_TRD;
        end
        S_TRD: state <= S_TWR;
        S_TWR: begin
          i_r   <= bp_rd;
          k_r   <= k_r - PW'(1);
          state <= (k_r == PW'(2)) ? S_ERD : S_TRD;
        end
        S_ERD: state <= S_EWAIT;
        S_EWAIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid   <= 1'b1;
            out_ch.is_last <= (j_r == kopt_r);
            if (j_r == '0) begin
              out_ch.boundary <= BND_W'(1);
            end else if (j_r == kopt_r) begin
              out_ch.boundary <= BND_W'(n_r) + BND_W'(1);
            end else begin
              out_ch.boundary <= buf_rd;
            end
            if (j_r == kopt_r) begin
              state <= S_IDLE;
            end else begin
              j_r   <= j_r + PW'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `IPDP_ASSERT_IMP(a_scan_range, clk, rst, state == S_SCAN, (i_r != '0) && (i_r <= n_r) && (c_r < i_r))
  `IPDP_ASSERT_NXT(a_solve_busy, clk, rst, in_acc && (in_ch.command == CMD_SOLVE), !in_ch.ready)
  `IPDP_ASSERT_IMP(a_trace_round, clk, rst, state == S_TRD, (k_r >= PW'(2)) && (k_r <= kmax_r))
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for interval_partition_dp: loads the cost table up to
// the largest size solved, walks a short directed table (trivial sizes, cost
// extremes, dropped writes, tie break), then runs random phases over several
// size settings with sender gaps, receiver stalls and one long receiver hold.
// Every boundary transaction is checked against an in-bench model of the
// segmentation solve, or against typed boundaries for some directed solves.
// ----------------------------------------------------------------------------
module tb_top;
  import ipdp_pkg::*;

  localparam int NPOS        = 32;
  localparam int NLOAD       = 20;     // largest size used by a non-trivial solve
  localparam int PHASE_ITEMS = 27;     // items per random phase
  localparam int WD_LIMIT    = 200000; // idle cycles before giving up
  localparam int HOLD_LEN    = 400;    // long receiver hold, in cycles

  typedef enum int {ROW_SET_N, ROW_SET_K, ROW_WRITE, ROW_SOLVE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          s;
    int          e;
    int          cost;
    int          nfix;   // 0: predicted, 2: two typed boundaries below
    bit [5:0]    fix0;
    bit [5:0]    fix1;
  } dir_row_t;

  typedef struct {
    bit [BND_W-1:0] boundary;
    bit             is_last;
  } bound_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PROBLEM_SIZE;
  logic [SIZE_W-1:0]    cfg_data  = '0;

  ipdp_in_if  in_ch();
  ipdp_out_if out_ch();

  interval_partition_dp u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #6 clk = ~clk;

  // Bench copy of the block's state: cost table and the two size registers.
  longint      seg_costs [1:NPOS][1:NPOS];
  int unsigned size_reg;
  int unsigned limit_reg;

  bound_t pending_bounds[$];  // boundaries still owed by the block
  int     err_cnt = 0;

  // Idling knobs, set per phase by the stimulus process.
  int send_gap_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;     // bumped (NBA) to request one long hold

  // --------------------------------------------------------------------------
  // Segmentation model: fills pending_bounds with the boundaries of one solve
  // --------------------------------------------------------------------------
  function automatic longint clamp_path(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (PATH_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void predict_boundaries();
    int unsigned n;
    int unsigned kmax;
    int unsigned cur;
    int unsigned prv;
    int unsigned kopt;
    int unsigned at;
    int unsigned cnt;
    int unsigned pick;
    int unsigned kseen;
    int unsigned kc;
    longint      pcost;
    longint      sum;
    longint      path[2][NPOS+1];
    int unsigned segs[2][NPOS+1];
    int unsigned backptr[NPOS+1][NPOS+1];
    bit [5:0]    bnd[NPOS+2];
    bound_t      b;
    n    = (size_reg > NPOS) ? NPOS : size_reg;
    kmax = (limit_reg > n) ? n : limit_reg;
    if (kmax <= 1 || n <= 1) begin
      bnd[0] = 6'd1;
      bnd[1] = 6'(n + 1);
      cnt = 2;
    end else begin
      for (int i = 1; i <= n; i++) begin
        path[0][i] = clamp_path(seg_costs[1][i]);
        path[1][i] = path[0][i];
        segs[0][i] = 1;
        segs[1][i] = 1;
      end
      for (int i = 0; i <= NPOS; i++)
        for (int k = 0; k <= NPOS; k++) backptr[i][k] = 1;
      cur = 0;
      for (int k = 2; k <= kmax; k++) begin
        cur = k & 1;
        prv = 1 - cur;
        for (int i = 1; i <= n; i++) begin
          pick  = i;
          kseen = 1;
          pcost = clamp_path(seg_costs[1][i]);
          for (int c = 1; c < i; c++) begin
            sum = clamp_path(path[prv][c] + seg_costs[c+1][i]);
            kc  = segs[prv][c] + 1;
            // strictly cheaper wins; on a tie, fewer segments wins
            if (sum < pcost || (sum == pcost && kc < kseen)) begin
              pick  = c;
              pcost = sum;
              kseen = kc;
            end
          end
          path[cur][i]  = pcost;
          segs[cur][i]  = kseen;
          backptr[i][k] = pick;
        end
      end
      kopt = segs[cur][n];
      if (kopt < 1) kopt = 1;
      if (kopt > kmax) kopt = kmax;
      bnd[0]    = 6'd1;
      bnd[kopt] = 6'(n + 1);
      at = n;
      for (int k = kopt; k > 1; k--) begin
        bnd[k-1] = 6'(backptr[at][k] + 1);
        at = backptr[at][k];
      end
      cnt = kopt + 1;
    end
    for (int j = 0; j < cnt; j++) begin
      b.boundary = bnd[j];
      b.is_last  = (j + 1 == cnt);
      pending_bounds.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers (all entered and left on a rising-edge time step)
  // --------------------------------------------------------------------------
  task automatic send_item(bit cmd, int s, int e, int cost);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.seg_start <= 6'(s);
    in_ch.seg_end   <= 6'(e);
    in_ch.seg_cost  <= cost;
    do @(posedge clk); while (!in_ch.ready);
    // transaction taken: update the model
    if (cmd == CMD_WRITE) begin
      if (s >= 1 && s <= NPOS && e >= 1 && e <= NPOS) seg_costs[s][e] = longint'(cost);
    end
    if ($urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic solve_predicted();
    send_item(CMD_SOLVE, 0, 0, 0);
  endtask

  // Wait until the block owes nothing, then let a write in flight settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 6'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_PROBLEM_SIZE) size_reg = val & 6'h3f;
    else limit_reg = val & 6'h3f;
  endtask

  task automatic set_sizes(int unsigned n, int unsigned k);
    drain();
    write_reg(CFG_PROBLEM_SIZE, n);
    write_reg(CFG_SEGMENT_LIMIT, k);
  endtask

  function automatic int rand_cost();
    case ($urandom_range(3))
      0, 1: return int'($urandom_range(8)) - 4;  // small values make ties
      2:    return int'($urandom);
      default: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  initial begin
    int n_ph;
    int k_ph;
    int s;
    int e;
    bound_t fb;
    int phase_n[9];
    int phase_k[9];

    phase_n = '{NLOAD, 5, 8, 12, 3, 16, 1, NLOAD, NLOAD};
    phase_k = '{NLOAD, 3, 8, 4, 32, 16, 32, 2, 6};

    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_WRITE;
    in_ch.seg_start = '0;
    in_ch.seg_end   = '0;
    in_ch.seg_cost  = '0;
    size_reg  = 32;
    limit_reg = 32;

    dir_rows = '{
      '{ROW_SET_N, 1,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_SOLVE, 0,  0, 0, 2, 6'd1, 6'd2},   // single position
      '{ROW_SET_N, 32, 0, 0, 0, 6'd0, 6'd0},
      '{ROW_SET_K, 1,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_SOLVE, 0,  0, 0, 2, 6'd1, 6'd33},  // one segment allowed
      '{ROW_SET_K, 32, 0, 0, 0, 6'd0, 6'd0},
      '{ROW_SET_N, NLOAD, 0, 0, 0, 6'd0, 6'd0},
      '{ROW_WRITE, 0,  5, 7, 0, 6'd0, 6'd0},   // start 0: dropped
      '{ROW_WRITE, 33, 5, 7, 0, 6'd0, 6'd0},   // start past the table: dropped
      '{ROW_WRITE, 5,  63, 7, 0, 6'd0, 6'd0},  // end past the table: dropped
      '{ROW_WRITE, 7,  3, -9, 0, 6'd0, 6'd0},  // reversed, stored, never read
      '{ROW_WRITE, 1, NLOAD, 32'sh7fffffff, 0, 6'd0, 6'd0},
      '{ROW_SOLVE, 0,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_WRITE, 1, NLOAD, 32'sh80000000, 0, 6'd0, 6'd0},
      '{ROW_SOLVE, 0,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_SET_N, 2,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_SET_K, 2,  0, 0, 0, 6'd0, 6'd0},
      '{ROW_WRITE, 1,  1, 0, 0, 6'd0, 6'd0},
      '{ROW_WRITE, 2,  2, 0, 0, 6'd0, 6'd0},
      '{ROW_WRITE, 1,  2, 0, 0, 6'd0, 6'd0},
      '{ROW_SOLVE, 0,  0, 0, 2, 6'd1, 6'd3}    // equal cost: fewer segments
    };

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every entry with start <= end <= NLOAD so no solve reads a stale cell.
    for (int a = 1; a <= NLOAD; a++)
      for (int b = a; b <= NLOAD; b++) send_item(CMD_WRITE, a, b, rand_cost());

    // Directed table
    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_SET_N: begin
          drain();
          write_reg(CFG_PROBLEM_SIZE, dir_rows[r].s);
        end
        ROW_SET_K: begin
          drain();
          write_reg(CFG_SEGMENT_LIMIT, dir_rows[r].s);
        end
        ROW_WRITE: send_item(CMD_WRITE, dir_rows[r].s, dir_rows[r].e, dir_rows[r].cost);
        default: begin
          if (dir_rows[r].nfix == 2) begin
            fb.boundary = dir_rows[r].fix0; fb.is_last = 1'b0; pending_bounds.push_back(fb);
            fb.boundary = dir_rows[r].fix1; fb.is_last = 1'b1; pending_bounds.push_back(fb);
          end else begin
            predict_boundaries();
          end
          send_item(CMD_SOLVE, 0, 0, 0);
        end
      endcase
    end

    // Random phases: mostly well-formed writes inside the active size,
    // some solves, a little noise. Idling mode rotates with the phase.
    for (int ph = 0; ph < 9; ph++) begin
      n_ph = phase_n[ph];
      k_ph = phase_k[ph];
      set_sizes(n_ph, k_ph);
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 51; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 51; end
        default: begin send_gap_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if ($urandom_range(99) < ((n_ph >= 16) ? 8 : 18)) begin
          predict_boundaries();
          solve_predicted();
        end else if ($urandom_range(99) < 8) begin
          case ($urandom_range(2))
            0: send_item(CMD_WRITE, 0, $urandom_range(63), rand_cost());
            1: send_item(CMD_WRITE, $urandom_range(33, 63), $urandom_range(63), rand_cost());
            default: begin
              e = $urandom_range(1, 31);
              send_item(CMD_WRITE, $urandom_range(e + 1, 32), e, rand_cost());
            end
          endcase
        end else begin
          s = $urandom_range(1, n_ph);
          e = $urandom_range(s, n_ph);
          send_item(CMD_WRITE, s, e, rand_cost());
        end
      end
    end

    // Back pressure: receiver holds off while solves keep coming, so the
    // block's output backs up and its input stalls.
    set_sizes(6, 6);
    send_gap_pct  = 0;
    recv_stall_pct = 0;
    hold_ticket <= hold_ticket + 1;
    for (int it = 0; it < 8; it++) begin
      predict_boundaries();
      solve_predicted();
    end

    drain();
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold when a ticket is pending
  // --------------------------------------------------------------------------
  initial begin
    int served;
    served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    bound_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_bounds.size() == 0) begin
        report_mismatch("unexpected boundary", out_ch.boundary, -1);
      end else begin
        want = pending_bounds.pop_front();
        if (out_ch.boundary !== want.boundary)
          report_mismatch("boundary", out_ch.boundary, want.boundary);
        if (out_ch.is_last !== want.is_last)
          report_mismatch("is_last", out_ch.is_last, want.is_last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transaction on either channel
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
